// ===== hw/rtl/qau_pkg.sv =====
// Shared codes and constant tables for the quaternion arithmetic unit.
`timescale 1ns / 1ps

package qau_pkg;

	localparam int KIND_W   = 4;
	localparam int STATUS_W = 2;
	localparam int LANES    = 4;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD   = 4'd0,
		KIND_SUB   = 4'd1,
		KIND_PROD  = 4'd2,
		KIND_QUOT  = 4'd3,
		KIND_SCALE = 4'd4,
		KIND_DIVS  = 4'd5,
		KIND_NEG   = 4'd6,
		KIND_CONJ  = 4'd7,
		KIND_INV   = 4'd8,
		KIND_DOT   = 4'd9,
		KIND_LENSQ = 4'd10,
		KIND_LEN   = 4'd11,
		KIND_NORM  = 4'd12
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK  = 2'd0,
		ST_OVF = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	// Hamilton product: lane i, term k multiplies a[k] by y[i ^ k]; these bits
	// mark the terms that are subtracted. Indexed [lane][term].
	localparam logic [LANES-1:0][LANES-1:0] HAM_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

endpackage

// ===== hw/rtl/qau_in_if.sv =====
// Operand channel: two quaternions, a scalar and an operation code.
`timescale 1ns / 1ps

interface qau_in_if
	import qau_pkg::*;
#(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic        [KIND_W-1:0]     kind;
	logic signed [DATA_WIDTH-1:0] a_w;
	logic signed [DATA_WIDTH-1:0] a_x;
	logic signed [DATA_WIDTH-1:0] a_y;
	logic signed [DATA_WIDTH-1:0] a_z;
	logic signed [DATA_WIDTH-1:0] b_w;
	logic signed [DATA_WIDTH-1:0] b_x;
	logic signed [DATA_WIDTH-1:0] b_y;
	logic signed [DATA_WIDTH-1:0] b_z;
	logic signed [DATA_WIDTH-1:0] scalar_in;

	modport source (
		output valid, kind, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar_in,
		input  ready
	);
	modport sink (
		input  valid, kind, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar_in,
		output ready
	);
endinterface

// ===== hw/rtl/qau_out_if.sv =====
// Result channel: one quaternion, one scalar and a status code.
`timescale 1ns / 1ps

interface qau_out_if
	import qau_pkg::*;
#(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] r_w;
	logic signed [DATA_WIDTH-1:0] r_x;
	logic signed [DATA_WIDTH-1:0] r_y;
	logic signed [DATA_WIDTH-1:0] r_z;
	logic signed [DATA_WIDTH-1:0] r_scalar;
	logic        [STATUS_W-1:0]   status;

	modport source (
		output valid, r_w, r_x, r_y, r_z, r_scalar, status,
		input  ready
	);
	modport sink (
		input  valid, r_w, r_x, r_y, r_z, r_scalar, status,
		output ready
	);
endinterface

// ===== hw/rtl/qau_delay.sv =====
// Enabled shift line that keeps side data level with a pipelined unit.
`timescale 1ns / 1ps

module qau_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);
	logic [DEPTH-1:0][WIDTH-1:0] sr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q <= '0;
		end else if (en) begin
			sr_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				sr_q[i] <= sr_q[i-1];
			end
		end
	end

	assign q = sr_q[DEPTH-1];
endmodule

// ===== hw/rtl/qau_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module qau_sqrt #(
	parameter int IN_W = 66
) (
	input  logic              clk,
	input  logic              en,
	input  logic [IN_W-1:0]   x,
	output logic [IN_W/2-1:0] root
);
	localparam int RW  = IN_W / 2;
	localparam int RMW = RW + 3;

	logic [RMW-1:0]  rem_q  [RW];
	logic [RW-1:0]   root_q [RW];
	logic [IN_W-1:0] x_q    [RW];

	logic [RMW-1:0]  rem_p  [RW];
	logic [RMW-1:0]  trial  [RW];
	logic [RMW-1:0]  tval   [RW];
	logic [RW-1:0]   root_p [RW];
	logic [IN_W-1:0] x_p    [RW];
	logic [RW-1:0]   ge;

	always_comb begin
		for (int k = 0; k < RW; k++) begin
			if (k == 0) begin
				rem_p[k]  = '0;
				root_p[k] = '0;
				x_p[k]    = x;
			end else begin
				rem_p[k]  = rem_q[k-1];
				root_p[k] = root_q[k-1];
				x_p[k]    = x_q[k-1];
			end
			// bring down the next two radicand bits, try root bit 1
			trial[k] = {rem_p[k][RMW-3:0], x_p[k][IN_W-1 -: 2]};
			tval[k]  = RMW'({root_p[k], 2'b01});
			ge[k]    = trial[k] >= tval[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RW; k++) begin
				rem_q[k]  <= ge[k] ? trial[k] - tval[k] : trial[k];
				root_q[k] <= {root_p[k][RW-2:0], ge[k]};
				x_q[k]    <= x_p[k] << 2;
			end
		end
	end

	assign root = root_q[RW-1];
endmodule

// ===== hw/rtl/qau_div.sv =====
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
`timescale 1ns / 1ps

module qau_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);
	localparam int REM_W = DEN_W + 1;

	logic [REM_W-1:0] rem_q [NUM_W];
	logic [NUM_W-1:0] nq_q  [NUM_W];
	logic [DEN_W-1:0] d_q   [NUM_W];

	logic [REM_W-1:0] rem_p [NUM_W];
	logic [REM_W-1:0] trial [NUM_W];
	logic [NUM_W-1:0] nq_p  [NUM_W];
	logic [DEN_W-1:0] d_p   [NUM_W];
	logic [NUM_W-1:0] ge;

	always_comb begin
		for (int k = 0; k < NUM_W; k++) begin
			if (k == 0) begin
				rem_p[k] = '0;
				nq_p[k]  = num;
				d_p[k]   = den;
			end else begin
				rem_p[k] = rem_q[k-1];
				nq_p[k]  = nq_q[k-1];
				d_p[k]   = d_q[k-1];
			end
			// numerator bits leave at the top, quotient bits enter at the bottom
			trial[k] = {rem_p[k][DEN_W-1:0], nq_p[k][NUM_W-1]};
			ge[k]    = trial[k] >= {1'b0, d_p[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_W; k++) begin
				rem_q[k] <= ge[k] ? trial[k] - {1'b0, d_p[k]} : trial[k];
				nq_q[k]  <= {nq_p[k][NUM_W-2:0], ge[k]};
				d_q[k]   <= d_p[k];
			end
		end
	end

	assign quo = nq_q[NUM_W-1];
endmodule

// ===== hw/rtl/qau_lane.sv =====
// One product lane: four signed products, signed sum, fraction shift, saturation.
`timescale 1ns / 1ps

module qau_lane
	import qau_pkg::*;
#(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [LANES-1:0][W-1:0]   p,
	input  logic [LANES-1:0][W-1:0]   q,
	input  logic [LANES-1:0]          neg,
	output logic [W-1:0]              res,
	output logic                      ov
);
	localparam int PW = 2 * W + 3;
	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	logic signed [2*W-1:0] prod_s1 [LANES];
	logic [LANES-1:0]      neg_s1;
	logic signed [PW-1:0]  sum;
	logic signed [PW-1:0]  sh;
	logic                  sat;
	logic [W-1:0]          res_s2;
	logic                  ov_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LANES; k++) begin
				prod_s1[k] <= $signed(p[k]) * $signed(q[k]);
			end
			neg_s1 <= neg;
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < LANES; k++) begin
			sum = neg_s1[k] ? sum - PW'(prod_s1[k]) : sum + PW'(prod_s1[k]);
		end
		sh  = sum >>> F;
		// out of range unless every bit from the sign of the result up agrees
		sat = !((&sh[PW-1:W-1]) || !(|sh[PW-1:W-1]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= sat ? (sh[PW-1] ? VMIN : VMAX) : sh[W-1:0];
			ov_s2  <= sat;
		end
	end

	assign res = res_s2;
	assign ov  = ov_s2;
endmodule

// ===== hw/rtl/quaternion_arithmetic_unit_top.sv =====
// Quaternion ALU top level: sqrt and divider lanes, product lanes, result merge.
//
//  channel  dir  handshake     word
//  cmd      in   valid/ready   kind, a_w..a_z, b_w..b_z, scalar_in
//  rsp      out  valid/ready   r_w..r_z, r_scalar, status
//
// One word accepted per cycle while the output register is empty or being taken;
// the path runs through the root pipeline (DATA_WIDTH+1 stages) followed by
// the divider lanes (DATA_WIDTH+FRAC_BITS stages); the defaults give Q16.16.
// Every operation takes the same path, so words leave in order.
// All stages move together: the pipe advances whenever the output register is
// empty or being taken, so cmd.ready falls only while a finished word waits.
// arst_n clears all valid bits; no clearing pass is needed after reset.
`timescale 1ns / 1ps

module quaternion_arithmetic_unit_top
	import qau_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	qau_in_if.sink    cmd,
	qau_out_if.source rsp
);
	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int XW = 2 * W + 2;    // sum of four squares, even for the root
	localparam int RW = XW / 2;       // root bits
	localparam int NW = W + F;        // shifted numerator and quotient bits
	localparam logic [W-1:0]  VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  VMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [NW-1:0] HALF = NW'(VMIN);
	localparam logic [NW-1:0] QMAX = NW'(VMAX);

	typedef struct packed {
		logic                  valid;
		kind_t                 kind;
		logic [LANES-1:0][W-1:0] a;
		logic [LANES-1:0][W-1:0] b;
		logic [W-1:0]          s;
	} item_t;

	typedef struct packed {
		item_t        it;
		logic [W-1:0] scal;
		logic         dz;
		logic         ov;
	} tag_t;

	typedef struct packed {
		tag_t                    tag;
		logic [LANES-1:0][W-1:0] t;
	} late_t;

	function automatic logic [W-1:0] sat_w(input logic [W:0] v);
		logic [W-1:0] r;
		if (v[W] != v[W-1]) begin
			r = v[W] ? VMIN : VMAX;
		end else begin
			r = v[W-1:0];
		end
		return r;
	endfunction

	function automatic logic ovf_w(input logic [W:0] v);
		return v[W] != v[W-1];
	endfunction

	logic en;
	assign en        = !rsp.valid || rsp.ready;
	assign cmd.ready = en;

	// ---------------------------------------------------------------- s1: squares
	item_t                   it_in;
	logic [LANES-1:0][W-1:0] q_in;
	logic signed [2*W-1:0]   sq_full [LANES];
	item_t                   it_s1;
	logic [2*W-2:0]          sq_s1 [LANES];

	always_comb begin
		it_in.valid = cmd.valid;
		it_in.kind  = kind_t'(cmd.kind);
		it_in.a     = {cmd.a_z, cmd.a_y, cmd.a_x, cmd.a_w};
		it_in.b     = {cmd.b_z, cmd.b_y, cmd.b_x, cmd.b_w};
		it_in.s     = cmd.scalar_in;
		// quotient needs the length of B, everything else that of A
		q_in        = (it_in.kind == KIND_QUOT) ? it_in.b : it_in.a;
		for (int i = 0; i < LANES; i++) begin
			sq_full[i] = $signed(q_in[i]) * $signed(q_in[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_s1 <= '0;
		end else if (en) begin
			it_s1 <= it_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				sq_s1[i] <= sq_full[i][2*W-2:0];
			end
		end
	end

	// ---------------------------------------------------------------- s2: sum of squares
	item_t          it_s2;
	logic [XW-1:0]  ssq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_s2 <= '0;
		end else if (en) begin
			it_s2 <= it_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ssq_s2 <= XW'(sq_s1[0]) + XW'(sq_s1[1]) + XW'(sq_s1[2]) + XW'(sq_s1[3]);
		end
	end

	// ---------------------------------------------------------------- root
	logic [RW-1:0] root_r;
	item_t         it_r;
	logic [XW-1:0] ssq_r;

	qau_sqrt #(.IN_W(XW)) u_sqrt (
		.clk  (clk),
		.en   (en),
		.x    (ssq_s2),
		.root (root_r)
	);

	qau_delay #(.WIDTH($bits(item_t) + XW), .DEPTH(RW)) u_dly_root (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      ({it_s2, ssq_s2}),
		.q      ({it_r, ssq_r})
	);

	// ---------------------------------------------------------------- s3: divider set-up
	logic [XW-1:0]           len2_sh;
	logic                    len2_ov;
	logic [W-1:0]            len2;
	logic                    len_ov;
	logic [W-1:0]            lenv;
	logic [LANES-1:0][W-1:0] nsrc;
	logic                    conj;
	logic [W-1:0]            den;
	tag_t                    tag_c;
	logic [W:0]              nv   [LANES];
	logic [W:0]              nabs [LANES];
	logic [LANES-1:0]        nneg;
	logic [W-1:0]            dabs;
	logic                    dneg;

	assign len2_sh = ssq_r >> F;
	assign len2_ov = |len2_sh[XW-1:W-1];
	assign len2    = len2_ov ? VMAX : len2_sh[W-1:0];
	assign len_ov  = |root_r[RW-1:W-1];
	assign lenv    = len_ov ? VMAX : root_r[W-1:0];

	always_comb begin
		tag_c.it   = it_r;
		tag_c.scal = '0;
		tag_c.dz   = 1'b0;
		tag_c.ov   = 1'b0;
		nsrc       = it_r.a;
		conj       = 1'b0;
		den        = it_r.s;
		case (it_r.kind)
			KIND_INV: begin
				conj     = 1'b1;
				den      = len2;
				tag_c.dz = len2 == '0;
				tag_c.ov = len2_ov;
			end
			KIND_QUOT: begin
				nsrc     = it_r.b;
				conj     = 1'b1;
				den      = len2;
				tag_c.dz = len2 == '0;
				tag_c.ov = len2_ov;
			end
			KIND_DIVS: begin
				tag_c.dz = it_r.s == '0;
			end
			KIND_NORM: begin
				den      = lenv;
				tag_c.dz = lenv == '0;
				tag_c.ov = len_ov;
			end
			KIND_LENSQ: begin
				tag_c.scal = len2;
				tag_c.ov   = len2_ov;
			end
			KIND_LEN: begin
				tag_c.scal = lenv;
				tag_c.ov   = len_ov;
			end
			default: begin
			end
		endcase
		dneg = den[W-1];
		dabs = dneg ? W'(-den) : den;
		// inverse and quotient take the conjugate; one extra bit so that negating the
		// most negative value is exact
		for (int i = 0; i < LANES; i++) begin
			nv[i]   = (conj && i != 0) ? -{nsrc[i][W-1], nsrc[i]} : {nsrc[i][W-1], nsrc[i]};
			nneg[i] = nv[i][W];
			nabs[i] = nneg[i] ? -nv[i] : nv[i];
		end
	end

	tag_t             tag_s3;
	logic [W-1:0]     nmag_s3 [LANES];
	logic [W-1:0]     dmag_s3;
	logic [LANES-1:0] qneg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else if (en) begin
			tag_s3 <= tag_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				nmag_s3[i]    <= nabs[i][W-1:0];
				qneg_s3[i]    <= nneg[i] ^ dneg;
			end
			dmag_s3 <= dabs;
		end
	end

	// ---------------------------------------------------------------- divider lanes
	logic [NW-1:0]    quo [LANES];
	tag_t             tag_d;
	logic [LANES-1:0] qneg_d;

	for (genvar i = 0; i < LANES; i++) begin : g_div
		qau_div #(.NUM_W(NW), .DEN_W(W)) u_div (
			.clk (clk),
			.en  (en),
			.num ({nmag_s3[i], {F{1'b0}}}),
			.den (dmag_s3),
			.quo (quo[i])
		);
	end

	qau_delay #(.WIDTH($bits(tag_t) + LANES), .DEPTH(NW)) u_dly_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      ({tag_s3, qneg_s3}),
		.q      ({tag_d, qneg_d})
	);

	// ---------------------------------------------------------------- s4: quotient sign and saturation
	logic [LANES-1:0]        qov;
	logic [LANES-1:0][W-1:0] tq;
	logic                    div_kind;
	late_t                   late_c;
	late_t                   late_s4;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (qneg_d[i]) begin
				qov[i] = quo[i] > HALF;
				tq[i]  = qov[i] ? VMIN : W'(-quo[i]);
			end else begin
				qov[i] = quo[i] > QMAX;
				tq[i]  = qov[i] ? VMAX : quo[i][W-1:0];
			end
		end
		div_kind     = tag_d.it.kind inside {KIND_QUOT, KIND_DIVS, KIND_INV, KIND_NORM};
		late_c.tag   = tag_d;
		late_c.tag.ov = tag_d.ov | (div_kind & (|qov));
		late_c.t     = tq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			late_s4 <= '0;
		end else if (en) begin
			late_s4 <= late_c;
		end
	end

	// ---------------------------------------------------------------- product lanes
	logic [LANES-1:0][LANES-1:0][W-1:0] lp;
	logic [LANES-1:0][LANES-1:0][W-1:0] lq;
	logic [LANES-1:0][LANES-1:0]        lneg;
	logic [LANES-1:0][W-1:0]            yv;
	logic [1:0]                         yi;
	logic [LANES-1:0][W-1:0]            lres;
	logic [LANES-1:0]                   lov;

	always_comb begin
		yv   = (late_s4.tag.it.kind == KIND_QUOT) ? late_s4.t : late_s4.tag.it.b;
		lp   = '0;
		lq   = '0;
		lneg = '0;
		yi   = '0;
		for (int i = 0; i < LANES; i++) begin
			for (int k = 0; k < LANES; k++) begin
				yi = 2'(i ^ k);
				case (late_s4.tag.it.kind)
					KIND_PROD, KIND_QUOT: begin
						lp[i][k]   = late_s4.tag.it.a[k];
						lq[i][k]   = yv[yi];
						lneg[i][k] = HAM_NEG[i][k];
					end
					KIND_DOT: begin
						if (i == 0) begin
							lp[i][k] = late_s4.tag.it.a[k];
							lq[i][k] = late_s4.tag.it.b[k];
						end
					end
					KIND_SCALE: begin
						if (k == 0) begin
							lp[i][k] = late_s4.tag.it.a[i];
							lq[i][k] = late_s4.tag.it.s;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		qau_lane #(.W(W), .F(F)) u_lane (
			.clk (clk),
			.en  (en),
			.p   (lp[i]),
			.q   (lq[i]),
			.neg (lneg[i]),
			.res (lres[i]),
			.ov  (lov[i])
		);
	end

	late_t late_s5;
	late_t late_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			late_s5 <= '0;
			late_s6 <= '0;
		end else if (en) begin
			late_s5 <= late_s4;
			late_s6 <= late_s5;
		end
	end

	// ---------------------------------------------------------------- merge and output register
	logic [LANES-1:0][W-1:0] rq;
	logic [W-1:0]            rs;
	logic                    mov;
	status_t                 st;
	logic [W:0]              ext;
	logic                    rv_q;
	logic [LANES-1:0][W-1:0] rq_q;
	logic [W-1:0]            rs_q;
	status_t                 st_q;

	always_comb begin
		rq  = '0;
		rs  = '0;
		mov = late_s6.tag.ov;
		ext = '0;
		case (late_s6.tag.it.kind)
			KIND_ADD, KIND_SUB, KIND_NEG, KIND_CONJ: begin
				for (int i = 0; i < LANES; i++) begin
					case (late_s6.tag.it.kind)
						KIND_ADD: ext = {late_s6.tag.it.a[i][W-1], late_s6.tag.it.a[i]}
							+ {late_s6.tag.it.b[i][W-1], late_s6.tag.it.b[i]};
						KIND_SUB: ext = {late_s6.tag.it.a[i][W-1], late_s6.tag.it.a[i]}
							- {late_s6.tag.it.b[i][W-1], late_s6.tag.it.b[i]};
						default: begin
							// conjugate keeps the real part
							if (late_s6.tag.it.kind == KIND_CONJ && i == 0) begin
								ext = {late_s6.tag.it.a[i][W-1], late_s6.tag.it.a[i]};
							end else begin
								ext = -{late_s6.tag.it.a[i][W-1], late_s6.tag.it.a[i]};
							end
						end
					endcase
					rq[i] = sat_w(ext);
					mov   = mov | ovf_w(ext);
				end
			end
			KIND_PROD, KIND_QUOT, KIND_SCALE: begin
				rq  = lres;
				mov = mov | (|lov);
			end
			KIND_INV, KIND_DIVS, KIND_NORM: begin
				rq = late_s6.t;
			end
			KIND_DOT: begin
				rs  = lres[0];
				mov = mov | lov[0];
			end
			KIND_LENSQ, KIND_LEN: begin
				rs = late_s6.tag.scal;
			end
			default: begin
			end
		endcase
		// a zero divisor clears everything and wins over overflow
		if (late_s6.tag.dz) begin
			rq = '0;
			rs = '0;
			st = ST_DZ;
		end else begin
			st = mov ? ST_OVF : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (en) begin
			rv_q <= late_s6.tag.it.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rq_q <= rq;
			rs_q <= rs;
			st_q <= st;
		end
	end

	assign rsp.valid    = rv_q;
	assign rsp.r_w      = rq_q[0];
	assign rsp.r_x      = rq_q[1];
	assign rsp.r_y      = rq_q[2];
	assign rsp.r_z      = rq_q[3];
	assign rsp.r_scalar = rs_q;
	assign rsp.status   = st_q;

	// ---------------------------------------------------------------- checks
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_DZ |->
			rsp.r_w == '0 && rsp.r_x == '0 && rsp.r_y == '0 && rsp.r_z == '0
			&& rsp.r_scalar == '0)
		else $error("divide-by-zero word carries non-zero fields");

	a_scalar_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.r_scalar != '0 |->
			rsp.r_w == '0 && rsp.r_x == '0 && rsp.r_y == '0 && rsp.r_z == '0)
		else $error("scalar result alongside a quaternion result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(late_s6) && $stable(late_s4))
		else $error("pipeline moved while stalled");

endmodule
